// File: hw/rtl/xorshift_keystream_byte_cipher_unit_defines.svh
// Assertion macros used by the checker of the keystream byte cipher.
// Depends on nothing; the using scope must provide clk_i and rst_ni.
`ifndef XORSHIFT_KEYSTREAM_BYTE_CIPHER_UNIT_DEFINES_SVH
`define XORSHIFT_KEYSTREAM_BYTE_CIPHER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define XKC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, also while reset is applied.
`define XKC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/xkc_pkg.sv
// Types and constants of the keystream byte cipher.
// Used by the channel interfaces, the top level and the checker.
package xkc_pkg;

  typedef enum logic {
    OP_KEYX = 1'b0,
    OP_DATA = 1'b1
  } opcode_e;

  localparam logic [31:0] RDR_KEY_RESET = 32'h1424_3444;
  localparam logic [31:0] READER_MIX0   = 32'h0549_1333;
  localparam logic [31:0] HOST_MIX1     = 32'h1F12_3BB5;
  localparam logic [31:0] READER_MIX2   = 32'h159A_55E5;
  localparam logic [31:0] HOST_MIX3     = 32'h075B_CD15;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] host_word;
    logic [7:0]  data_in;
    logic        start_of_message;
  } req_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [31:0] key_reply;
    logic        was_keyed;
  } rsp_t;

endpackage

// File: hw/rtl/xkc_if.sv
// Valid/ready channel interfaces for request and result items.
// Depends on xkc_pkg for the payload types.
interface xkc_req_if;
  logic          valid;
  logic          ready;
  xkc_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface xkc_rsp_if;
  logic          valid;
  logic          ready;
  xkc_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/xorshift_keystream_byte_cipher_unit.sv
// Top level of the keystream byte cipher: input register, cipher step, result register.
// Depends on xkc_pkg and the channel interfaces in xkc_if.sv.
//
//  channel  direction  contents
//  in_i     sink       opcode, host_word, data_in, start_of_message
//  out_o    source     data_out, key_reply, was_keyed
//  cfg      write      reader key word (cfg_we_i, cfg_wdata_i)
//
// Each item is held in the input register and then sits in the result register.
// One item per cycle is accepted while the output is taken.
// The key state update and the xorshift step are done combinationally between the registers.
// A stalled output holds its item; the input register fills once and then drops ready.
// Reset clears the key state, the byte phase, the keyed flag and both valid flags.
module xorshift_keystream_byte_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  xkc_req_if.sink     in_i,
  xkc_rsp_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import xkc_pkg::*;

  function automatic logic [31:0] xs_next(input logic [31:0] w0, input logic [31:0] w3);
    logic [31:0] t;
    t = w3 ^ (w3 << 11);
    return w0 ^ (w0 >> 19) ^ t ^ (t >> 8);
  endfunction

  logic [31:0] rdr_key_q;
  logic        in_vld_q;
  req_t        req_q;
  logic        out_vld_q;
  rsp_t        rsp_q, rsp_d;
  logic [31:0] kw_q [4];
  logic [31:0] kw_d [4];
  logic [1:0]  phase_q, phase_d, phase_eff;
  logic        keyed_q, keyed_d;
  logic        out_free, step;
  logic [31:0] kw0_use;
  logic [7:0]  ks_byte;

  assign out_free    = !out_vld_q || out_o.ready;
  assign step        = in_vld_q && out_free;
  assign in_i.ready  = !in_vld_q || out_free;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = rsp_q;

  always_comb begin
    kw_d      = kw_q;
    phase_d   = phase_q;
    keyed_d   = keyed_q;
    phase_eff = req_q.start_of_message ? 2'd0 : phase_q;
    kw0_use   = (phase_eff == 2'd0) ? xs_next(kw_q[0], kw_q[3]) : kw_q[0];
    case (phase_eff)
      2'd0:    ks_byte = kw0_use[31:24];
      2'd1:    ks_byte = kw0_use[23:16];
      2'd2:    ks_byte = kw0_use[15:8];
      default: ks_byte = kw0_use[7:0];
    endcase
    rsp_d = '0;
    if (req_q.opcode == OP_KEYX) begin
      kw_d[0] = rdr_key_q ^ READER_MIX0;
      kw_d[1] = req_q.host_word ^ HOST_MIX1;
      kw_d[2] = rdr_key_q ^ READER_MIX2;
      kw_d[3] = req_q.host_word ^ HOST_MIX3;
      keyed_d = 1'b1;
      phase_d = 2'd0;
      rsp_d.key_reply = rdr_key_q;
      rsp_d.was_keyed = 1'b1;
    end else if (!keyed_q) begin
      phase_d = phase_eff;
      rsp_d.data_out = req_q.data_in;
    end else begin
      if (phase_eff == 2'd0) begin
        kw_d[0] = kw0_use;
        kw_d[1] = kw_q[0];
        kw_d[2] = kw_q[1];
        kw_d[3] = kw_q[2];
      end
      phase_d = phase_eff + 2'd1;
      rsp_d.data_out  = req_q.data_in ^ ks_byte;
      rsp_d.was_keyed = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdr_key_q <= RDR_KEY_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      kw_q      <= '{default: '0};
      phase_q   <= 2'd0;
      keyed_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rdr_key_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (step) begin
        kw_q    <= kw_d;
        phase_q <= phase_d;
        keyed_q <= keyed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.payload;
    end
    if (step) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// File: hw/rtl/xkc_checker.sv
// Port-level checker for the keystream byte cipher and its bind to the top level.
// Depends on xkc_pkg and the assertion macros header.
`include "xorshift_keystream_byte_cipher_unit_defines.svh"

module xkc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input xkc_pkg::rsp_t out_payload_i
);
  import xkc_pkg::*;

  `XKC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i), "Stalled result item changed or vanished.")
  `XKC_ASSERT(a_reply_keyed, out_valid_i && out_payload_i.key_reply != '0 |-> out_payload_i.was_keyed, "Key reply on an unkeyed item.")
  `XKC_ASSERT(a_plain_no_reply, out_valid_i && !out_payload_i.was_keyed |-> out_payload_i.key_reply == '0, "Pass-through item carries a key reply.")
  `XKC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_i, "Result valid right after reset.")

endmodule

bind xorshift_keystream_byte_cipher_unit xkc_checker u_xkc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
